>>> rtl/pes_pkg.sv
// Shared types, codes and helpers for the periodic event scheduler.
package pes_pkg;

  localparam int MAX_SOURCES_DEF = 64;
  localparam int ID_W            = 16;
  localparam int PER_W           = 16;
  localparam int DUE_W           = 32;
  localparam int CMD_W           = 2;
  // insertion order tag, wide enough for the largest table
  localparam int SEQ_W           = 10;

  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_INSERT  = 2'd2,
    OP_REPLACE = 2'd3
  } op_t;

  typedef struct packed {
    logic             valid;
    logic [DUE_W-1:0] due;
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] seq;
    logic [PER_W-1:0] period;
  } entry_t;

  typedef struct packed {
    logic   step;
    op_t    op;
    entry_t key;
  } cell_ctl_t;

  // strict ordering on (due, id, insertion order)
  function automatic logic precedes(entry_t a, entry_t b);
    return {a.due, a.id, a.seq} < {b.due, b.id, b.seq};
  endfunction

  function automatic logic [DUE_W-1:0] sat_add(logic [DUE_W-1:0] due,
                                               logic [PER_W-1:0] per);
    logic [DUE_W:0] sum;
    sum = {1'b0, due} + {{(DUE_W+1-PER_W){1'b0}}, per};
    return sum[DUE_W] ? {DUE_W{1'b1}} : sum[DUE_W-1:0];
  endfunction

endpackage

>>> rtl/pes_if.sv
// Valid/ready channel interfaces for scheduler commands and dispatch results.
interface pes_in_if;
  logic                        valid;
  logic                        ready;
  logic [pes_pkg::CMD_W-1:0]   command;
  logic [pes_pkg::ID_W-1:0]    source_id;
  logic [pes_pkg::PER_W-1:0]   period;

  modport source (output valid, command, source_id, period, input ready);
  modport sink   (input valid, command, source_id, period, output ready);
endinterface

interface pes_out_if;
  logic                        valid;
  logic                        ready;
  logic [pes_pkg::ID_W-1:0]    chosen_id;
  logic [pes_pkg::DUE_W-1:0]   due_time;
  logic                        empty_res;

  modport source (output valid, chosen_id, due_time, empty_res, input ready);
  modport sink   (input valid, chosen_id, due_time, empty_res, output ready);
endinterface

>>> rtl/pes_cell.sv
// One slot of the sorted source chain: holds an entry, shifts with its neighbors.
module pes_cell #(
  parameter logic HEAD = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pes_pkg::cell_ctl_t ctl_i,
  input  pes_pkg::entry_t    left_i,
  input  logic               left_prec_i,
  input  pes_pkg::entry_t    right_i,
  input  logic               right_prec_i,
  output pes_pkg::entry_t    entry_o,
  output logic               prec_o
);

  pes_pkg::entry_t entry_r;
  pes_pkg::entry_t entry_nxt;

  assign entry_o = entry_r;
  assign prec_o  = entry_r.valid && pes_pkg::precedes(entry_r, ctl_i.key);

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl_i.op)
      pes_pkg::OP_CLEAR: begin
        entry_nxt.valid = 1'b0;
      end
      pes_pkg::OP_INSERT: begin
        if (!prec_o) begin
          entry_nxt = (left_prec_i || HEAD) ? ctl_i.key : left_i;
        end
      end
      pes_pkg::OP_REPLACE: begin
        // head leaves; later entries move up until the new key fits
        if (right_prec_i) begin
          entry_nxt = right_i;
        end else if (prec_o || HEAD) begin
          entry_nxt = ctl_i.key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (ctl_i.step) begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.step) begin
      entry_r.due    <= entry_nxt.due;
      entry_r.id     <= entry_nxt.id;
      entry_r.seq    <= entry_nxt.seq;
      entry_r.period <= entry_nxt.period;
    end
  end

endmodule

>>> rtl/periodic_event_scheduler_top.sv
// Periodic event scheduler: a chain of cells kept sorted by due time, id, then add order.
// Every command has an accept phase and an execute phase: the accept cycle latches it (for a
// dispatch it reads the head cell and forms the advanced due time); on execution the key goes to all
// cells, which compare in parallel and shift one place toward or away from the head.
// No new command is accepted until the previous one has executed; a dispatch whose result cannot enter the
// output register waits in the busy state until the previous result is taken. Clear empties the table
// in one step; adds to a full table are dropped; a dispatch on an empty table returns
// empty_res with zero id and due time. MAX_SOURCES may range from 2 to 1024.
module periodic_event_scheduler_top #(
  parameter int MAX_SOURCES = pes_pkg::MAX_SOURCES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  pes_in_if.sink   in_if,
  pes_out_if.source out_if
);

  localparam int CNT_W = $clog2(MAX_SOURCES + 1);

  pes_pkg::entry_t    ent  [MAX_SOURCES];
  logic               prec [MAX_SOURCES];
  pes_pkg::cell_ctl_t ctl;

  logic                        busy_r;
  pes_pkg::op_t                op_r;
  pes_pkg::entry_t             key_r;
  logic                        res_need_r;
  logic [pes_pkg::ID_W-1:0]    res_id_r;
  logic [pes_pkg::DUE_W-1:0]   res_due_r;
  logic                        res_empty_r;
  logic [CNT_W-1:0]            count_r;

  logic                        out_valid_r;
  logic [pes_pkg::ID_W-1:0]    out_id_r;
  logic [pes_pkg::DUE_W-1:0]   out_due_r;
  logic                        out_empty_r;

  logic            in_acc;
  logic            exec_go;
  logic            out_load;
  pes_pkg::entry_t head_next;
  pes_pkg::entry_t add_key;

  assign in_if.ready = !busy_r;
  assign in_acc      = in_if.valid && !busy_r;
  assign exec_go     = busy_r && !(res_need_r && out_valid_r && !out_if.ready);
  assign out_load    = exec_go && res_need_r;

  assign ctl.step = exec_go;
  assign ctl.op   = op_r;
  assign ctl.key  = key_r;

  always_comb begin
    head_next     = ent[0];
    head_next.due = pes_pkg::sat_add(ent[0].due, ent[0].period);
    add_key.valid  = 1'b1;
    add_key.due    = {{(pes_pkg::DUE_W-pes_pkg::PER_W){1'b0}}, in_if.period};
    add_key.id     = in_if.source_id;
    add_key.seq    = pes_pkg::SEQ_W'(count_r);
    add_key.period = in_if.period;
  end

  generate
    for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
      pes_pkg::entry_t left_e;
      pes_pkg::entry_t right_e;
      logic            left_p;
      logic            right_p;
      if (i == 0) begin : g_first
        assign left_e = '0;
        assign left_p = 1'b1;
      end else begin : g_mid_l
        assign left_e = ent[i-1];
        assign left_p = prec[i-1];
      end
      if (i == MAX_SOURCES - 1) begin : g_last
        assign right_e = '0;
        assign right_p = 1'b0;
      end else begin : g_mid_r
        assign right_e = ent[i+1];
        assign right_p = prec[i+1];
      end
      pes_cell #(
        .HEAD (i == 0)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_i        (ctl),
        .left_i       (left_e),
        .left_prec_i  (left_p),
        .right_i      (right_e),
        .right_prec_i (right_p),
        .entry_o      (ent[i]),
        .prec_o       (prec[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      op_r       <= pes_pkg::OP_NONE;
      res_need_r <= 1'b0;
      count_r    <= '0;
    end else if (in_acc) begin
      busy_r     <= 1'b1;
      op_r       <= pes_pkg::OP_NONE;
      res_need_r <= 1'b0;
      unique case (in_if.command)
        pes_pkg::CMD_CLEAR: begin
          op_r    <= pes_pkg::OP_CLEAR;
          count_r <= '0;
        end
        pes_pkg::CMD_ADD: begin
          if (count_r < CNT_W'(MAX_SOURCES)) begin
            op_r    <= pes_pkg::OP_INSERT;
            count_r <= count_r + CNT_W'(1);
          end
        end
        pes_pkg::CMD_DISPATCH: begin
          res_need_r <= 1'b1;
          if (count_r != '0) begin
            op_r <= pes_pkg::OP_REPLACE;
          end
        end
        default: begin
        end
      endcase
    end else if (exec_go) begin
      busy_r <= 1'b0;
      op_r   <= pes_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r       <= (in_if.command == pes_pkg::CMD_ADD) ? add_key : head_next;
      res_empty_r <= (count_r == '0);
      res_id_r    <= (count_r == '0) ? '0 : ent[0].id;
      res_due_r   <= (count_r == '0) ? '0 : ent[0].due;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id_r    <= res_id_r;
      out_due_r   <= res_due_r;
      out_empty_r <= res_empty_r;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.chosen_id = out_id_r;
  assign out_if.due_time  = out_due_r;
  assign out_if.empty_res = out_empty_r;

endmodule

>>> rtl/pes_checker.sv
// Port-level checks for the scheduler top, attached by bind.
module pes_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [pes_pkg::ID_W-1:0]  out_chosen_id,
  input logic [pes_pkg::DUE_W-1:0] out_due_time,
  input logic                      out_empty_res
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen_id) &&
                                $stable(out_due_time) && $stable(out_empty_res))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while the previous one executes");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_chosen_id == '0 && out_due_time == '0)
    else $error("empty result with nonzero fields");

  a_out_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready || $past(!in_ready))
    else $error("result appeared without a transaction in flight");

endmodule

bind periodic_event_scheduler_top pes_checker u_pes_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_chosen_id (out_if.chosen_id),
  .out_due_time  (out_if.due_time),
  .out_empty_res (out_if.empty_res)
);

>>> verif/periodic_event_scheduler_top_tb.sv
// Self-checking testbench for the periodic event scheduler: directed cases and random traffic.
module periodic_event_scheduler_top_tb;

  localparam int TABLE_DEPTH = pes_pkg::MAX_SOURCES_DEF;
  localparam logic [pes_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam logic [pes_pkg::PER_W-1:0] PERIOD_MAX = '1;
  localparam logic [pes_pkg::ID_W-1:0] ID_MAX = '1;

  typedef struct packed {
    logic [pes_pkg::ID_W-1:0]  id;
    logic [pes_pkg::DUE_W-1:0] due;
    logic                      empty;
  } dispatch_t;

  logic clk = 1'b0;
  logic rst_n;

  pes_in_if  in_ch();
  pes_out_if out_ch();

  periodic_event_scheduler_top #(.MAX_SOURCES(TABLE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #4 clk = ~clk;

  // scheduler table mirror
  logic                      src_valid  [TABLE_DEPTH];
  logic [pes_pkg::ID_W-1:0]  src_id     [TABLE_DEPTH];
  logic [pes_pkg::PER_W-1:0] src_period [TABLE_DEPTH];
  logic [pes_pkg::DUE_W-1:0] src_due    [TABLE_DEPTH];
  int unsigned               src_count;

  dispatch_t pending_dispatches[$];
  int err_count = 0;
  int idle_pct  = 0;
  int stall_pct = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  task automatic schedule_command(logic [pes_pkg::CMD_W-1:0] cmd,
                                  logic [pes_pkg::ID_W-1:0] sid,
                                  logic [pes_pkg::PER_W-1:0] per);
    int best;
    logic [pes_pkg::DUE_W:0] sum;
    dispatch_t d;
    case (cmd)
      pes_pkg::CMD_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) src_valid[i] = 1'b0;
        src_count = 0;
      end
      pes_pkg::CMD_ADD: begin
        if (src_count < TABLE_DEPTH) begin
          src_valid[src_count]  = 1'b1;
          src_id[src_count]     = sid;
          src_period[src_count] = per;
          src_due[src_count]    = {{(pes_pkg::DUE_W-pes_pkg::PER_W){1'b0}}, per};
          src_count++;
        end
      end
      pes_pkg::CMD_DISPATCH: begin
        best = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (src_valid[i] && (best < 0 || src_due[i] < src_due[best] ||
              (src_due[i] == src_due[best] && src_id[i] < src_id[best])))
            best = i;
        end
        if (best < 0) begin
          d = '{id: '0, due: '0, empty: 1'b1};
        end else begin
          d = '{id: src_id[best], due: src_due[best], empty: 1'b0};
          sum = {1'b0, src_due[best]} +
                {{(pes_pkg::DUE_W+1-pes_pkg::PER_W){1'b0}}, src_period[best]};
          src_due[best] = sum[pes_pkg::DUE_W] ? '1 : sum[pes_pkg::DUE_W-1:0];
        end
        pending_dispatches.push_back(d);
      end
      default: ;
    endcase
  endtask

  // drive one transaction; returns right after the accepting edge
  task automatic send_command(logic [pes_pkg::CMD_W-1:0] cmd,
                              logic [pes_pkg::ID_W-1:0] sid,
                              logic [pes_pkg::PER_W-1:0] per);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.command   = cmd;
    in_ch.source_id = sid;
    in_ch.period    = per;
    do @(posedge clk); while (!in_ch.ready);
    schedule_command(cmd, sid, per);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_dispatches.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) out_ch.ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_result
    dispatch_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dispatches.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_ch.chosen_id), '0);
      end else begin
        want = pending_dispatches.pop_front();
        if (out_ch.chosen_id !== want.id)
          report_mismatch("chosen_id", 64'(out_ch.chosen_id), 64'(want.id));
        if (out_ch.due_time !== want.due)
          report_mismatch("due_time", 64'(out_ch.due_time), 64'(want.due));
        if (out_ch.empty_res !== want.empty)
          report_mismatch("empty_res", 64'(out_ch.empty_res), 64'(want.empty));
      end
    end
  end

  task automatic test_empty_dispatch();
    send_command(pes_pkg::CMD_DISPATCH, ID_MAX, PERIOD_MAX);
    send_command(pes_pkg::CMD_CLEAR, '0, '0);
    send_command(pes_pkg::CMD_DISPATCH, '0, '0);
    settle();
  endtask

  task automatic test_field_extremes();
    send_command(pes_pkg::CMD_ADD, ID_MAX, PERIOD_MAX);
    send_command(pes_pkg::CMD_ADD, '0, 16'd1);
    send_command(pes_pkg::CMD_ADD, 16'h5a5a, '0);
    send_command(pes_pkg::CMD_DISPATCH, '0, '0);
    send_command(pes_pkg::CMD_DISPATCH, '0, '0);
    send_command(CMD_RESERVED, ID_MAX, PERIOD_MAX);
    send_command(pes_pkg::CMD_DISPATCH, ID_MAX, PERIOD_MAX);
    send_command(pes_pkg::CMD_CLEAR, ID_MAX, PERIOD_MAX);
    send_command(pes_pkg::CMD_DISPATCH, '0, '0);
    settle();
  endtask

  task automatic test_ties();
    send_command(pes_pkg::CMD_ADD, 16'd7, 16'd5);
    send_command(pes_pkg::CMD_ADD, 16'd3, 16'd5);
    send_command(pes_pkg::CMD_ADD, 16'd3, 16'd5);
    send_command(pes_pkg::CMD_ADD, 16'd9, 16'd5);
    repeat (6) send_command(pes_pkg::CMD_DISPATCH, '0, '0);
    send_command(pes_pkg::CMD_CLEAR, '0, '0);
    settle();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < TABLE_DEPTH + 3; i++)
      send_command(pes_pkg::CMD_ADD, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(1, 200)));
    repeat (12) send_command(pes_pkg::CMD_DISPATCH, '0, '0);
    send_command(pes_pkg::CMD_CLEAR, '0, '0);
    settle();
  endtask

  // due times grow past 16 bits
  task automatic test_long_period();
    send_command(pes_pkg::CMD_ADD, 16'hbeef, PERIOD_MAX);
    send_command(pes_pkg::CMD_ADD, 16'h1234, 16'hfff0);
    repeat (40) send_command(pes_pkg::CMD_DISPATCH, '0, '0);
    send_command(pes_pkg::CMD_CLEAR, '0, '0);
    settle();
  endtask

  // episodes start with a clear; the mode picks narrow, full or mixed field ranges (full ids, narrow periods)
  task automatic test_random_phase(int n_items, int idle, int stall);
    int sent;
    int len;
    int mode;
    int r;
    logic [pes_pkg::ID_W-1:0] sid;
    logic [pes_pkg::PER_W-1:0] per;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      send_command(pes_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom));
      sent++;
      len  = $urandom_range(10, 160);
      mode = $urandom_range(0, 2);
      for (int k = 0; k < len && sent < n_items; k++) begin
        case (mode)
          0: begin
            sid = 16'($urandom_range(0, 7));
            per = 16'($urandom_range(1, 4));
          end
          1: begin
            sid = 16'($urandom);
            per = 16'($urandom);
          end
          default: begin
            sid = 16'($urandom);
            per = 16'($urandom_range(0, 3));
          end
        endcase
        r = $urandom_range(99);
        if (r < 2) begin
          send_command(CMD_RESERVED, 16'($urandom), 16'($urandom));
        end else if (r < 45) begin
          send_command(pes_pkg::CMD_ADD, sid, per);
          sent++;
        end else begin
          send_command(pes_pkg::CMD_DISPATCH, 16'($urandom), 16'($urandom));
          sent++;
        end
      end
    end
    settle();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.command   = pes_pkg::CMD_CLEAR;
    in_ch.source_id = '0;
    in_ch.period    = '0;
    rst_n           = 1'b0;
    schedule_command(pes_pkg::CMD_CLEAR, '0, '0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_dispatch();
    test_field_extremes();
    test_ties();
    test_full_table();
    test_long_period();
    test_random_phase(350, 0, 0);
    test_random_phase(350, 80, 0);
    test_random_phase(350, 0, 80);
    test_random_phase(350, 22, 22);

    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("periodic_event_scheduler_top regression: pass");
    end else begin
      $display("periodic_event_scheduler_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("periodic_event_scheduler_top regression: fail");
    $finish;
  end

endmodule
